// File: rtl/rlc_pkg.sv
// Shared types, codes and an arithmetic helper for the RGBA layer compositor.
`timescale 1ns / 1ps

package rlc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_CANVAS_WIDTH  = 3'd0;
    localparam logic [2:0] REG_CANVAS_HEIGHT = 3'd1;
    localparam logic [2:0] REG_ORIGIN_X      = 3'd2;
    localparam logic [2:0] REG_ORIGIN_Y      = 3'd3;
    localparam logic [2:0] REG_BLEND_MODE    = 3'd4;

    // Command codes carried on the input tuser.
    localparam logic CMD_BLEND = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Blend mode codes.
    localparam logic MODE_NORMAL   = 1'b0;
    localparam logic MODE_MULTIPLY = 1'b1;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int SIZE_W      = 9;
    localparam int PIXEL_W     = 32;
    localparam int S_DATA_W    = 64;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
    localparam logic [7:0]        FULL       = 8'd255;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;    // accept an input beat and read the canvas
        logic commit;  // write back the blended pixel and load the output
        logic clear;   // write zero at the clear counter
    } rlc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;  // clear counter is on the final word
        logic out_free;    // output register can take a result this cycle
    } rlc_status_t;

    // Exact floor(v / 255) for v up to 255 * 255.
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, v} + {9'd0, v[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

// File: rtl/rlc_ctrl.sv
// Controller state machine: clearing pass, beat acceptance and write-back sequencing.
`timescale 1ns / 1ps

module rlc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  rlc_pkg::rlc_status_t status,
    output rlc_pkg::rlc_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_MIX   = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next-state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take   = 1'b1;
                    state_next = ST_MIX;
                end
            end
            ST_MIX: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // An accepted beat is always followed by its write-back state.
    a_take_then_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |=> state_reg == ST_MIX)
        else $error("accepted beat not followed by write-back state");

    // No beat is taken until the clearing pass has finished.
    a_no_take_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |-> !s_tready)
        else $error("input ready during clearing pass");

    // Only one command is active in any cycle.
    a_one_command: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.take, cmd.commit, cmd.clear}))
        else $error("overlapping controller commands");

endmodule

// File: rtl/rlc_datapath.sv
// Datapath: configuration registers, address clipping, canvas memory, blend and output register.
`timescale 1ns / 1ps

module rlc_datapath #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rlc_pkg::rlc_cmd_t                   cmd,
    output rlc_pkg::rlc_status_t                status,
    input  logic                                s_tuser,
    input  logic [rlc_pkg::S_DATA_W-1:0]        s_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rlc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rlc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rlc_pkg::PIXEL_W-1:0]         m_tdata,
    output logic                                m_tuser
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW     = rlc_pkg::SIZE_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [SW-1:0]     MAX_W_SZ  = SW'(MAX_WIDTH);
    localparam logic [SW-1:0]     MAX_H_SZ  = SW'(MAX_HEIGHT);

    // Configuration registers.
    logic [SW-1:0] width_reg;
    logic [SW-1:0] height_reg;
    logic [15:0]   origin_x_reg;
    logic [15:0]   origin_y_reg;
    logic          mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= rlc_pkg::SIZE_RESET;
            height_reg   <= rlc_pkg::SIZE_RESET;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            mode_reg     <= rlc_pkg::MODE_NORMAL;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rlc_pkg::REG_CANVAS_WIDTH:  width_reg    <= cfg_data[SW-1:0];
                rlc_pkg::REG_CANVAS_HEIGHT: height_reg   <= cfg_data[SW-1:0];
                rlc_pkg::REG_ORIGIN_X:      origin_x_reg <= cfg_data;
                rlc_pkg::REG_ORIGIN_Y:      origin_y_reg <= cfg_data;
                rlc_pkg::REG_BLEND_MODE:    mode_reg     <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Effective canvas size, limited by the memory geometry.
    logic [SW-1:0] w_eff;
    logic [SW-1:0] h_eff;

    assign w_eff = (int'(width_reg) > MAX_WIDTH) ? MAX_W_SZ : width_reg;
    assign h_eff = (int'(height_reg) > MAX_HEIGHT) ? MAX_H_SZ : height_reg;

    // Target position, clip test and word address of the incoming beat.
    logic        in_cmd;
    logic [17:0] pos_x_s;
    logic [17:0] pos_y_s;
    logic        inside_next;
    logic [17:0] idx_prod;
    logic [17:0] idx_sum;
    logic [ADDR_W-1:0] addr_next;

    assign in_cmd  = s_tuser;
    assign pos_x_s = {2'b00, s_tdata[15:0]}
                   + ((in_cmd == rlc_pkg::CMD_BLEND) ? {{2{origin_x_reg[15]}}, origin_x_reg}
                                                     : 18'd0);
    assign pos_y_s = {2'b00, s_tdata[31:16]}
                   + ((in_cmd == rlc_pkg::CMD_BLEND) ? {{2{origin_y_reg[15]}}, origin_y_reg}
                                                     : 18'd0);
    assign inside_next = !pos_x_s[17] && !pos_y_s[17]
                      && (pos_x_s[16:0] < {8'd0, w_eff})
                      && (pos_y_s[16:0] < {8'd0, h_eff});
    assign idx_prod  = {{SW{1'b0}}, pos_y_s[SW-1:0]} * {{SW{1'b0}}, w_eff};
    assign idx_sum   = idx_prod + {9'd0, pos_x_s[SW-1:0]};
    assign addr_next = ADDR_W'(idx_sum);

    // Held item between acceptance and write-back.
    logic              cmd_reg;
    logic [31:0]       src_reg;
    logic              inside_reg;
    logic [ADDR_W-1:0] addr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            cmd_reg    <= in_cmd;
            src_reg    <= s_tdata[63:32];
            inside_reg <= inside_next;
            addr_reg   <= addr_next;
        end
    end

    // Clear counter for the pass over the canvas after reset.
    logic [ADDR_W-1:0] clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear) begin
            clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
        end
    end

    assign status.clear_last = (clr_cnt_reg == LAST_ADDR);

    // Single-port canvas memory with registered read data.
    logic [rlc_pkg::PIXEL_W-1:0] canvas_mem [DEPTH];
    logic [rlc_pkg::PIXEL_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]           mem_addr;
    logic                        mem_we;
    logic                        mem_re;
    logic [rlc_pkg::PIXEL_W-1:0] mem_wdata;
    logic [rlc_pkg::PIXEL_W-1:0] new_pix;
    logic                        skip;

    assign skip      = (cmd_reg == rlc_pkg::CMD_READ) || (src_reg[31:24] == 8'd0);
    assign mem_re    = cmd.take;
    assign mem_we    = cmd.clear || (cmd.commit && inside_reg && !skip);
    assign mem_wdata = cmd.clear ? '0 : new_pix;
    assign mem_addr  = cmd.clear ? clr_cnt_reg : (cmd.take ? addr_next : addr_reg);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            canvas_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= canvas_mem[mem_addr];
        end
    end

    // Blend of the held pixel over the stored canvas pixel; reads and zero source alpha keep it.
    always_comb begin
        logic [7:0]  s_a;
        logic [7:0]  d_a;
        logic [7:0]  inv_a;
        logic [15:0] acc;
        logic [8:0]  a_sum;
        s_a   = src_reg[31:24];
        d_a   = rd_data_reg[31:24];
        inv_a = rlc_pkg::FULL - s_a;
        a_sum = {1'b0, s_a} + {1'b0, d_a};
        new_pix = rd_data_reg;
        for (int c = 0; c < 3; c++) begin
            if (mode_reg == rlc_pkg::MODE_MULTIPLY) begin
                acc = {8'd0, rd_data_reg[c*8 +: 8]} * {8'd0, src_reg[c*8 +: 8]};
            end else begin
                acc = {8'd0, src_reg[c*8 +: 8]} * {8'd0, s_a}
                    + {8'd0, rd_data_reg[c*8 +: 8]} * {8'd0, inv_a};
            end
            if (!skip) begin
                new_pix[c*8 +: 8] = rlc_pkg::div255(acc);
            end
        end
        if (!skip) begin
            if (mode_reg == rlc_pkg::MODE_MULTIPLY) begin
                new_pix[31:24] = (s_a > d_a) ? s_a : d_a;
            end else begin
                new_pix[31:24] = a_sum[8] ? rlc_pkg::FULL : a_sum[7:0];
            end
        end
    end

    // Output register.
    logic                        m_valid_reg;
    logic [rlc_pkg::PIXEL_W-1:0] m_data_reg;
    logic                        m_inside_reg;

    assign status.out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_data_reg   <= inside_reg ? new_pix : '0;
            m_inside_reg <= inside_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_inside_reg;

    // The single memory port never reads and writes in the same cycle.
    a_port_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("canvas memory read and write in the same cycle");

    // A result is loaded only when the previous one has left or is leaving.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && !cmd.commit) |=> m_tvalid && $stable(m_tdata))
        else $error("pending result lost or changed");

    // A clipped item never produces a nonzero pixel.
    a_clipped_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && !inside_reg) |=> m_tdata == '0 && !m_tuser)
        else $error("clipped result carries pixel data");

endmodule

// File: rtl/rgba_layer_compositor_core.sv
// Top level of the RGBA layer compositor: controller and datapath.
// An accepted beat is held with its canvas read data, then blended into the
// output register at write-back; one canvas read and one write-back on the
// single memory port, no new beat before it; a stalled output holds write-back.
// Reset (aresetn low, synchronous) restores register defaults and starts a
// clearing pass over MAX_WIDTH*MAX_HEIGHT words, no input beat taken meanwhile.
`timescale 1ns / 1ps

module rgba_layer_compositor_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // tdata: pos_x[15:0], pos_y[31:16], src_red[39:32], src_green[47:40],
    //        src_blue[55:48], src_alpha[63:56]
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rlc_pkg::S_DATA_W-1:0]     s_tdata,
    // tuser: command[0]
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // tdata: out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
    output logic [rlc_pkg::PIXEL_W-1:0]      m_tdata,
    // tuser: inside_canvas[0]
    output logic                             m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rlc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rlc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    rlc_pkg::rlc_cmd_t    cmd;
    rlc_pkg::rlc_status_t status;

    // Sequencer.
    rlc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Address, memory and blend logic.
    rlc_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
